// ===== hdl/chm_pkg.sv =====
// chm_pkg: sizes, op and status codes, controller/datapath interface types
// and the bucket mix function for the counting hash multiset
// no dependencies
package chm_pkg;

  localparam int unsigned BUCKETS    = 512;
  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SIZE_BITS  = 26;

  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned ENTRY_W = $clog2(ENTRIES);
  localparam int unsigned PTR_W   = ENTRY_W + 1;

  localparam logic [PTR_W-1:0]      NIL       = PTR_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [BKT_W-1:0]      BKT_LAST  = BKT_W'(BUCKETS - 1);

  // operation codes
  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_REM_ONE = 3'd1;
  localparam logic [2:0] OP_REM_ALL = 3'd2;
  localparam logic [2:0] OP_COUNT   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [2:0] {
    S_CLR_RST,
    S_CLR_OP,
    S_IDLE,
    S_HEAD,
    S_LOAD,
    S_FETCH,
    S_CMP,
    S_ACT
  } chm_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic clr_done;
    logic head_rd;
    logic head_ld;
    logic node_rd;
    logic cmp;
    logic act;
  } chm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_clear;
    logic walk_end;
    logic key_hit;
    logic sweep_last;
  } chm_stat_t;

  // shift-xor mix, low bits pick the bucket
  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_BITS-1:0] k);
    logic [KEY_BITS-1:0] h1;
    logic [KEY_BITS-1:0] h2;
    h1 = k ^ (k >> 20) ^ (k >> 12);
    h2 = h1 ^ (h1 >> 7) ^ (h1 >> 4);
    return h2[BKT_W-1:0];
  endfunction

endpackage

// ===== hdl/chm_ctrl.sv =====
// chm_ctrl: sequencer for clear sweep, chain walk and update
// depends on chm_pkg
module chm_ctrl import chm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  chm_stat_t stat_i,
  output chm_cmd_t  cmd_o
);

  chm_state_e state_q, state_d;

  // state register, reset starts the bucket sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR_RST;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR_RST: if (stat_i.sweep_last) state_d = S_IDLE;
      S_CLR_OP:  if (stat_i.sweep_last) state_d = S_IDLE;
      S_IDLE: begin
        if (start) state_d = stat_i.op_clear ? S_CLR_OP : S_HEAD;
      end
      S_HEAD:  state_d = S_LOAD;
      S_LOAD:  state_d = S_FETCH;
      S_FETCH: state_d = stat_i.walk_end ? S_ACT : S_CMP;
      S_CMP:   state_d = stat_i.key_hit ? S_ACT : S_FETCH;
      S_ACT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      S_CLR_RST: cmd_o.clr_wr = 1'b1;
      S_CLR_OP: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.clr_done = stat_i.sweep_last;
      end
      S_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      S_HEAD:  cmd_o.head_rd = 1'b1;
      S_LOAD:  cmd_o.head_ld = 1'b1;
      S_FETCH: cmd_o.node_rd = !stat_i.walk_end;
      S_CMP:   cmd_o.cmp = 1'b1;
      S_ACT:   cmd_o.act = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== hdl/chm_dp.sv =====
// chm_dp: bucket heads, node pool, free stack, counters and result registers
// depends on chm_pkg
module chm_dp import chm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2:0]            op_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  chm_cmd_t              cmd_i,
  output chm_stat_t             stat_o,
  output logic                  found_o,
  output logic [COUNT_BITS-1:0] key_count_o,
  output logic [SIZE_BITS-1:0]  total_size_o,
  output logic [1:0]            status_o,
  output logic                  done_o
);

  // memories
  logic [PTR_W-1:0]      head_mem [BUCKETS];
  logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem  [ENTRIES];
  logic [PTR_W-1:0]      next_mem [ENTRIES];
  logic [ENTRY_W-1:0]    free_mem [ENTRIES];

  // transaction registers
  logic [2:0]            op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [BKT_W-1:0]      bkt_q;
  logic [PTR_W-1:0]      head_rd_q, head_q, cur_q, prev_q, nxt_q;
  logic [PTR_W-1:0]      steps_q;
  logic                  found_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [PTR_W-1:0]      next_rd_q;
  logic [ENTRY_W-1:0]    free_rd_q;

  // control state
  logic [PTR_W-1:0]      free_top_q, free_top_d;
  logic [PTR_W-1:0]      low_q, low_d;
  logic [SIZE_BITS-1:0]  size_q, size_d;
  logic [BKT_W-1:0]      clr_ptr_q;
  logic                  done_q;

  // result registers
  logic                  found_r_q;
  logic [COUNT_BITS-1:0] cnt_r_q;
  logic [1:0]            status_r_q;

  // update logic
  logic                  head_we, cnt_we, next_we, key_we, free_we;
  logic [BKT_W-1:0]      head_wa;
  logic [PTR_W-1:0]      head_wd, next_wd;
  logic [ENTRY_W-1:0]    cnt_wa, next_wa, key_wa, free_wa, free_wd;
  logic [COUNT_BITS-1:0] cnt_wd, res_cnt, dec_cnt;
  logic [1:0]            res_status;
  logic [PTR_W-1:0]      top_m1;
  logic [ENTRY_W-1:0]    alloc;
  logic                  unlink;

  assign top_m1 = free_top_q - PTR_W'(1);
  // below the low mark the stack still holds its reset contents
  assign alloc  = (top_m1 < low_q) ? top_m1[ENTRY_W-1:0] : free_rd_q;
  assign dec_cnt = (cnt_q != '0) ? cnt_q - COUNT_BITS'(1) : '0;

  // status to the controller
  assign stat_o.op_clear   = (op_i == OP_CLEAR);
  assign stat_o.walk_end   = (cur_q >= NIL) || (steps_q >= NIL);
  assign stat_o.key_hit    = (key_rd_q == key_q);
  assign stat_o.sweep_last = (clr_ptr_q == BKT_LAST);

  // operation decode and memory write selection
  always_comb begin
    head_we = 1'b0; head_wa = bkt_q; head_wd = NIL;
    cnt_we  = 1'b0; cnt_wa  = cur_q[ENTRY_W-1:0]; cnt_wd = '0;
    next_we = 1'b0; next_wa = prev_q[ENTRY_W-1:0]; next_wd = nxt_q;
    key_we  = 1'b0; key_wa  = alloc;
    free_we = 1'b0; free_wa = free_top_q[ENTRY_W-1:0]; free_wd = cur_q[ENTRY_W-1:0];
    free_top_d = free_top_q;
    low_d      = low_q;
    size_d     = size_q;
    res_cnt    = cnt_q;
    res_status = ST_OK;
    unlink     = 1'b0;
    if (cmd_i.clr_wr) begin
      head_we = 1'b1;
      head_wa = clr_ptr_q;
    end
    if (cmd_i.act) begin
      case (op_q)
        OP_PUT: begin
          if (found_q) begin
            if (cnt_q == COUNT_MAX) begin
              res_status = ST_SAT;
            end else begin
              res_cnt = cnt_q + COUNT_BITS'(1);
              cnt_we  = 1'b1;
              cnt_wd  = res_cnt;
              size_d  = size_q + SIZE_BITS'(1);
            end
          end else if (free_top_q == '0) begin
            res_status = ST_FULL;
          end else begin
            free_top_d = top_m1;
            if (top_m1 < low_q) low_d = top_m1;
            key_we  = 1'b1;
            cnt_we  = 1'b1;
            cnt_wa  = alloc;
            cnt_wd  = COUNT_BITS'(1);
            next_we = 1'b1;
            next_wa = alloc;
            next_wd = head_q;
            head_we = 1'b1;
            head_wd = {1'b0, alloc};
            res_cnt = COUNT_BITS'(1);
            size_d  = size_q + SIZE_BITS'(1);
          end
        end
        OP_REM_ONE: begin
          if (found_q) begin
            res_cnt = dec_cnt;
            if (size_q != '0) size_d = size_q - SIZE_BITS'(1);
            if (dec_cnt == '0) begin
              unlink = 1'b1;
            end else begin
              cnt_we = 1'b1;
              cnt_wd = dec_cnt;
            end
          end
        end
        OP_REM_ALL: begin
          if (found_q) begin
            res_cnt = '0;
            size_d  = (size_q >= SIZE_BITS'(cnt_q)) ? size_q - SIZE_BITS'(cnt_q) : '0;
            unlink  = 1'b1;
          end
        end
        default: res_status = ST_OK;
      endcase
      // take the node out of its chain and push it on the free stack
      if (unlink) begin
        if (prev_q < NIL) begin
          next_we = 1'b1;
        end else begin
          head_we = 1'b1;
          head_wd = nxt_q;
        end
        if (free_top_q < NIL) begin
          free_we    = 1'b1;
          free_top_d = free_top_q + PTR_W'(1);
        end
      end
    end
    // clear resets the counters at acceptance
    if (cmd_i.accept && op_i == OP_CLEAR) begin
      free_top_d = NIL;
      low_d      = NIL;
      size_d     = '0;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd_i.head_rd) head_rd_q <= head_mem[bkt_q];
  end

  always_ff @(posedge clk_i) begin
    if (key_we)  key_mem[key_wa]   <= key_q;
    if (cnt_we)  cnt_mem[cnt_wa]   <= cnt_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd_i.node_rd) begin
      key_rd_q  <= key_mem[cur_q[ENTRY_W-1:0]];
      cnt_rd_q  <= cnt_mem[cur_q[ENTRY_W-1:0]];
      next_rd_q <= next_mem[cur_q[ENTRY_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    if (cmd_i.head_rd) free_rd_q <= free_mem[top_m1[ENTRY_W-1:0]];
  end

  // transaction and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      key_q <= key_i;
      bkt_q <= bucket_of(key_i);
    end
    if (cmd_i.head_ld) begin
      head_q  <= head_rd_q;
      cur_q   <= head_rd_q;
      prev_q  <= NIL;
      steps_q <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
      nxt_q   <= NIL;
    end
    if (cmd_i.cmp) begin
      if (key_rd_q == key_q) begin
        found_q <= 1'b1;
        cnt_q   <= cnt_rd_q;
        nxt_q   <= next_rd_q;
      end else begin
        prev_q  <= cur_q;
        cur_q   <= next_rd_q;
        steps_q <= steps_q + PTR_W'(1);
      end
    end
    if (cmd_i.act) begin
      found_r_q  <= found_q;
      cnt_r_q    <= res_cnt;
      status_r_q <= res_status;
    end
    if (cmd_i.clr_done) begin
      found_r_q  <= 1'b0;
      cnt_r_q    <= '0;
      status_r_q <= ST_OK;
    end
  end

  // counters, sweep pointer and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q <= NIL;
      low_q      <= NIL;
      size_q     <= '0;
      clr_ptr_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      free_top_q <= free_top_d;
      low_q      <= low_d;
      size_q     <= size_d;
      if (cmd_i.clr_wr) clr_ptr_q <= clr_ptr_q + BKT_W'(1);
      done_q     <= cmd_i.act || cmd_i.clr_done;
    end
  end

  assign found_o      = found_r_q;
  assign key_count_o  = cnt_r_q;
  assign total_size_o = size_q;
  assign status_o     = status_r_q;
  assign done_o       = done_q;

`ifndef SYNTHESIS
  // free stack pointer never passes the pool size
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= NIL) else $error("free stack pointer out of range");
  // the low mark never sits above the stack pointer
  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= free_top_q) else $error("free stack low mark above pointer");
  // a refused put leaves the pool and size alone
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_r_q != ST_OK) |-> ($stable(free_top_q) && $stable(size_q)))
    else $error("refused put changed state");
  // sweep and update never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_wr && cmd_i.act)) else $error("sweep during update");
`endif

endmodule

// ===== hdl/counting_hash_multiset_top.sv =====
// counting_hash_multiset_top: counting hash multiset, controller plus datapath
// depends on chm_pkg, chm_ctrl, chm_dp
// operation: head read, head load, then a fetch and compare per chain node until a match
// or the chain end, then the update; clear sweeps all 512 buckets
// throughput: one operation at a time, the next one is accepted in the result cycle
// reset: a sweep over all 512 buckets runs with busy high; the receiver cannot stall
module counting_hash_multiset_top import chm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            op_i,
  input  logic [KEY_BITS-1:0]   key_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [COUNT_BITS-1:0] key_count_o,
  output logic [SIZE_BITS-1:0]  total_size_o,
  output logic [1:0]            status_o
);

  chm_cmd_t  cmd;
  chm_stat_t stat;

  chm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  chm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_i),
    .key_i        (key_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .found_o      (found_o),
    .key_count_o  (key_count_o),
    .total_size_o (total_size_o),
    .status_o     (status_o),
    .done_o       (done_o)
  );

endmodule
